// ===== design/sfsg_pkg.sv =====
`timescale 1ns / 1ps
package sfsg_pkg;

  localparam int COORD_FRACTION_BITS = 8;
  localparam int COORD_W = 24;
  localparam int HEIGHT_W = 16;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(10 << COORD_FRACTION_BITS);

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_GLYPH_HEIGHT = '0;

  // round(h*num/100): p = h*num + 50 stays below 2^23, exact with this reciprocal
  localparam int PROD_W = 23;
  localparam int RECIP_W = 24;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((1 << RECIP_SHIFT) + 99) / 100);
  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(50);

  typedef struct packed {
    logic [7:0]               char_code;
    logic                     first_char;
    logic                     last_char;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      segment_valid;
    logic                      last_of_glyph;
    logic [COORD_W-1:0]        text_width;
  } out_item_t;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  typedef struct packed {
    logic accept;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
    logic has_results;
    logic last_stroke;
    logic out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    SC_W, SC_HALF, SC_DA, SC_DB, SC_MMX, SC_MMY, SC_ADV
  } scale_sel_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] w;
    logic [HEIGHT_W-1:0] half;
    logic [HEIGHT_W-1:0] da;
    logic [HEIGHT_W-1:0] db;
    logic [HEIGHT_W-1:0] mmx;
    logic [HEIGHT_W-1:0] mmy;
    logic [HEIGHT_W-1:0] adv;
  } scales_t;

  typedef enum logic [3:0] {
    N_TL, N_TR, N_ML, N_MR, N_BL, N_BR, N_DA, N_DB, N_MM
  } node_t;

  typedef enum logic [3:0] {
    S_A, S_B, S_C, S_D, S_E, S_F, S_G, S_V, S_M1, S_M2, S_M3, S_M4, S_DOT
  } stroke_id_t;

  typedef enum logic [4:0] {
    SH_BLANK, SH_D0, SH_D1, SH_D2, SH_D3, SH_D4, SH_D5, SH_D6, SH_D7, SH_D8, SH_D9,
    SH_DOT, SH_DASH, SH_F, SH_P, SH_S, SH_M
  } shape_id_t;

  function automatic logic [6:0] scale_num(scale_sel_t sel);
    logic [6:0] n;
    unique case (sel)
      SC_W:    n = 7'd60;
      SC_HALF: n = 7'd50;
      SC_DA:   n = 7'd21;
      SC_DB:   n = 7'd33;
      SC_MMX:  n = 7'd30;
      SC_MMY:  n = 7'd55;
      SC_ADV:  n = 7'd81;
      default: n = 7'd0;
    endcase
    return n;
  endfunction

  function automatic shape_id_t shape_of(logic [7:0] c);
    shape_id_t sh;
    if (c >= 8'h30 && c <= 8'h39) begin
      sh = shape_id_t'(5'(c - 8'h30) + 5'd1);
    end else begin
      case (c)
        8'h2e:   sh = SH_DOT;
        8'h2d:   sh = SH_DASH;
        8'h46:   sh = SH_F;
        8'h50:   sh = SH_P;
        8'h53:   sh = SH_S;
        8'h4d:   sh = SH_M;
        default: sh = SH_BLANK;
      endcase
    end
    return sh;
  endfunction

  function automatic logic [2:0] shape_count(shape_id_t sh);
    logic [2:0] n;
    unique case (sh)
      SH_D0, SH_D6, SH_D9:        n = 3'd6;
      SH_D1:                      n = 3'd2;
      SH_D2, SH_D3, SH_D5, SH_S:  n = 3'd5;
      SH_D4, SH_P, SH_M:          n = 3'd4;
      SH_D7, SH_F:                n = 3'd3;
      SH_D8:                      n = 3'd7;
      SH_DOT, SH_DASH:            n = 3'd1;
      default:                    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic stroke_id_t shape_stroke(shape_id_t sh, logic [2:0] idx);
    stroke_id_t lst [7];
    lst = '{default: S_A};
    unique case (sh)
      SH_D0:   lst = '{S_A, S_B, S_C, S_D, S_E, S_F, S_A};
      SH_D1:   lst = '{S_B, S_C, S_A, S_A, S_A, S_A, S_A};
      SH_D2:   lst = '{S_A, S_B, S_G, S_E, S_D, S_A, S_A};
      SH_D3:   lst = '{S_A, S_B, S_G, S_C, S_D, S_A, S_A};
      SH_D4:   lst = '{S_F, S_G, S_B, S_C, S_A, S_A, S_A};
      SH_D5:   lst = '{S_A, S_F, S_G, S_C, S_D, S_A, S_A};
      SH_D6:   lst = '{S_A, S_F, S_G, S_E, S_C, S_D, S_A};
      SH_D7:   lst = '{S_A, S_B, S_C, S_A, S_A, S_A, S_A};
      SH_D8:   lst = '{S_A, S_B, S_C, S_D, S_E, S_F, S_G};
      SH_D9:   lst = '{S_A, S_B, S_C, S_D, S_F, S_G, S_A};
      SH_DOT:  lst = '{S_DOT, S_A, S_A, S_A, S_A, S_A, S_A};
      SH_DASH: lst = '{S_G, S_A, S_A, S_A, S_A, S_A, S_A};
      SH_F:    lst = '{S_V, S_A, S_G, S_A, S_A, S_A, S_A};
      SH_P:    lst = '{S_V, S_A, S_B, S_G, S_A, S_A, S_A};
      SH_S:    lst = '{S_A, S_F, S_G, S_C, S_D, S_A, S_A};
      SH_M:    lst = '{S_M1, S_M2, S_M3, S_M4, S_A, S_A, S_A};
      default: lst = '{default: S_A};
    endcase
    return lst[idx];
  endfunction

  function automatic node_t stroke_from(stroke_id_t s);
    node_t n;
    unique case (s)
      S_A, S_F, S_V, S_M3: n = N_TL;
      S_B:                 n = N_TR;
      S_C:                 n = N_MR;
      S_D, S_E, S_M1:      n = N_BL;
      S_G:                 n = N_ML;
      S_M2:                n = N_BR;
      S_M4:                n = N_MM;
      S_DOT:               n = N_DA;
      default:             n = N_TL;
    endcase
    return n;
  endfunction

  function automatic node_t stroke_to(stroke_id_t s);
    node_t n;
    unique case (s)
      S_A, S_M2, S_M4: n = N_TR;
      S_B, S_G:        n = N_MR;
      S_C, S_D:        n = N_BR;
      S_E, S_F:        n = N_ML;
      S_V:             n = N_BL;
      S_M1:            n = N_TL;
      S_M3:            n = N_MM;
      S_DOT:           n = N_DB;
      default:         n = N_TL;
    endcase
    return n;
  endfunction

endpackage

// ===== design/sfsg_scaler.sv =====
`timescale 1ns / 1ps
module sfsg_scaler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sfsg_pkg::HEIGHT_W-1:0] height,
  output sfsg_pkg::scales_t             scales,
  output logic                          busy
);
  import sfsg_pkg::*;

  logic                    running_r, running_nxt;
  scale_sel_t              cnt_r, cnt_nxt;
  logic                    v1_r;
  scale_sel_t              sel1_r;
  logic [PROD_W-1:0]       p_r;
  scales_t                 scales_r;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [HEIGHT_W-1:0]     quot;

  always_comb begin
    running_nxt = running_r;
    cnt_nxt     = cnt_r;
    if (start) begin
      running_nxt = 1'b1;
      cnt_nxt     = SC_W;
    end else if (running_r) begin
      cnt_nxt = scale_sel_t'(cnt_r + 3'd1);
      if (cnt_r == SC_ADV) begin
        running_nxt = 1'b0;
      end
    end
  end

  // table rebuild runs once out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b1;
      cnt_r     <= SC_W;
      v1_r      <= 1'b0;
    end else begin
      running_r <= running_nxt;
      cnt_r     <= cnt_nxt;
      v1_r      <= running_r && !start;
    end
  end

  always_ff @(posedge clk) begin
    sel1_r <= cnt_r;
    p_r    <= PROD_W'(height) * PROD_W'(scale_num(cnt_r)) + ROUND_BIAS;
  end

  assign recip_prod = (PROD_W+RECIP_W)'(p_r) * (PROD_W+RECIP_W)'(RECIP_M);
  assign quot       = recip_prod[RECIP_SHIFT +: HEIGHT_W];

  always_ff @(posedge clk) begin
    if (v1_r) begin
      case (sel1_r)
        SC_W:    scales_r.w    <= quot;
        SC_HALF: scales_r.half <= quot;
        SC_DA:   scales_r.da   <= quot;
        SC_DB:   scales_r.db   <= quot;
        SC_MMX:  scales_r.mmx  <= quot;
        SC_MMY:  scales_r.mmy  <= quot;
        default: scales_r.adv  <= quot;
      endcase
    end
  end

  assign scales = scales_r;
  assign busy   = running_r || v1_r;

  a_stage_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> $past(running_r))
    else $error("scaler stage two active without an issue");

endmodule

// ===== design/sfsg_ctrl.sv =====
`timescale 1ns / 1ps
module sfsg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sfsg_pkg::dp_status_t st,
  output sfsg_pkg::ctrl_cmd_t  cmd
);
  import sfsg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = st.busy;
        if (in_valid && !st.busy) begin
          cmd.accept = 1'b1;
          if (st.has_results) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.load = 1'b1;
          if (st.last_stroke) begin
            // next character may enter as the final segment goes out
            in_stall = st.busy;
            if (in_valid && !st.busy) begin
              cmd.accept = 1'b1;
              if (!st.has_results) begin
                state_nxt = ST_IDLE;
              end
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_emit_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && st.has_results) |=> state_r == ST_EMIT)
    else $error("character with results did not start emitting");

  a_no_rebuild_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !st.busy)
    else $error("scale table rebuilt while segments are pending");

endmodule

// ===== design/sfsg_datapath.sv =====
`timescale 1ns / 1ps
module sfsg_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sfsg_pkg::in_item_t              in_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfsg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  input  sfsg_pkg::ctrl_cmd_t             cmd,
  output sfsg_pkg::dp_status_t            st,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sfsg_pkg::out_item_t             out_data
);
  import sfsg_pkg::*;

  logic [HEIGHT_W-1:0] height_r;
  logic                cfg_wr;
  scales_t             scales;
  logic                scaler_busy;

  logic [COORD_W-1:0]  pen_x_r, start_x_r, top_y_r;
  logic [COORD_W-1:0]  cur_pen_r, cur_top_r, width_r;
  shape_id_t           shape_r;
  logic [2:0]          count_r, idx_r;
  logic                blank_r, last_r;

  logic [COORD_W-1:0]  pen_base, sx_base, pen_adv;
  shape_id_t           in_shape;
  logic [2:0]          in_count;
  logic                last_stroke;

  stroke_id_t          stroke;
  node_t               na, nb;
  out_item_t           res;
  out_item_t           out_r;
  logic                out_valid_r;

  function automatic logic [HEIGHT_W-1:0] node_x(node_t n, scales_t sc);
    logic [HEIGHT_W-1:0] v;
    unique case (n)
      N_TR, N_MR, N_BR: v = sc.w;
      N_DA:             v = sc.da;
      N_DB:             v = sc.db;
      N_MM:             v = sc.mmx;
      default:          v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [HEIGHT_W-1:0] node_y(node_t n, scales_t sc,
                                                 logic [HEIGHT_W-1:0] h);
    logic [HEIGHT_W-1:0] v;
    unique case (n)
      N_ML, N_MR:             v = sc.half;
      N_BL, N_BR, N_DA, N_DB: v = h;
      N_MM:                   v = sc.mmy;
      default:                v = '0;
    endcase
    return v;
  endfunction

  // configuration
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_GLYPH_HEIGHT);
  assign prdata = (paddr == ADDR_GLYPH_HEIGHT) ? {16'd0, height_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      height_r <= pwdata[HEIGHT_W-1:0];
    end
  end

  sfsg_scaler u_scaler (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_wr),
    .height (height_r),
    .scales (scales),
    .busy   (scaler_busy)
  );

  // pen bookkeeping at accept
  assign in_shape = shape_of(in_data.char_code);
  assign in_count = shape_count(in_shape);
  assign pen_base = in_data.first_char ? COORD_W'(in_data.origin_x) : pen_x_r;
  assign sx_base  = in_data.first_char ? COORD_W'(in_data.origin_x) : start_x_r;
  assign pen_adv  = pen_base + COORD_W'(scales.adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r   <= '0;
      start_x_r <= '0;
      top_y_r   <= '0;
    end else if (cmd.accept) begin
      pen_x_r   <= pen_adv;
      start_x_r <= sx_base;
      if (in_data.first_char) begin
        top_y_r <= COORD_W'(in_data.origin_y);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.accept) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_pen_r <= pen_base;
      cur_top_r <= in_data.first_char ? COORD_W'(in_data.origin_y) : top_y_r;
      width_r   <= pen_adv - sx_base;
      shape_r   <= in_shape;
      count_r   <= in_count;
      blank_r   <= (in_count == 3'd0);
      last_r    <= in_data.last_char;
    end
  end

  // segment of the current stroke
  assign last_stroke = blank_r || (idx_r == 3'(count_r - 3'd1));
  assign stroke      = shape_stroke(shape_r, idx_r);
  assign na          = stroke_from(stroke);
  assign nb          = stroke_to(stroke);

  always_comb begin
    res = '0;
    if (!blank_r) begin
      res.start_x       = cur_pen_r + COORD_W'(node_x(na, scales));
      res.start_y       = cur_top_r + COORD_W'(node_y(na, scales, height_r));
      res.end_x         = cur_pen_r + COORD_W'(node_x(nb, scales));
      res.end_y         = cur_top_r + COORD_W'(node_y(nb, scales, height_r));
      res.segment_valid = 1'b1;
    end
    res.last_of_glyph = last_stroke;
    res.text_width    = (last_stroke && last_r) ? width_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign st.busy        = scaler_busy || cfg_wr;
  assign st.has_results = (in_count != 3'd0) || in_data.last_char;
  assign st.last_stroke = last_stroke;
  assign st.out_free    = !out_valid_r || !out_stall;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (blank_r || idx_r < count_r))
    else $error("stroke index ran past the glyph");

endmodule

// ===== design/stroke_font_segment_generator.sv =====
`timescale 1ns / 1ps
// Stroke font segment generator: turns a text string, one character per input
// transfer, into line segments in screen pixels (signed, 8 fraction bits).
// Input channel in_valid/in_stall/in_data carries the character, the first and
// last flags and the string origin. Output channel out_valid/out_stall/out_data
// carries one segment per transfer; the last result of each glyph has
// last_of_glyph set, and on the last character it carries text_width.
// Glyph height is written through the APB-style port at address 0.
// The first segment is registered after the controller enters its emit state.
// The next character is taken in the cycle the final segment of its predecessor
// enters the output register; a blank character that is not last never enters
// the emit state, and a blank last character emits one result with text_width.
// The rate is set by the single segment builder, one stroke per cycle while the
// output is not stalled. After reset and after each glyph height write the scale
// table (seven constant products, one reciprocal multiply each) is rebuilt, with
// input stalled. Reset clears the pen and string origin to zero and height to
// 10 px. While the receiver stalls the pending segment holds; in emit state input waits.
module stroke_font_segment_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sfsg_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sfsg_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfsg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import sfsg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  assign pready = 1'b1;

  sfsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  sfsg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/stroke_font_segment_generator_checker.sv =====
`timescale 1ns / 1ps
module stroke_font_segment_generator_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  sfsg_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  sfsg_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfsg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  input  logic [31:0]                     prdata,
  input  logic                            pready,
  output int                              errors,
  output int                              outstanding,
  output int                              segments_checked
);
  import sfsg_pkg::*;

  logic [HEIGHT_W-1:0] height;
  logic [COORD_W-1:0]  pen_x;
  logic [COORD_W-1:0]  string_x;
  logic [COORD_W-1:0]  string_y;
  out_item_t           expected_segs[$];

  // round to nearest, ties up
  function automatic logic [COORD_W-1:0] scaled(logic [HEIGHT_W-1:0] h, int unsigned num,
                                                int unsigned den);
    int unsigned p;
    p = h * num + den / 2;
    return COORD_W'(p / den);
  endfunction

  function automatic void queue_result(out_item_t seg);
    expected_segs.insert(expected_segs.size(), seg);
  endfunction

  function automatic int glyph_strokes(logic [7:0] c, output stroke_id_t lst [7]);
    int n;
    lst = '{default: S_A};
    n = 0;
    case (c)
      "0": begin lst = '{S_A, S_B, S_C, S_D, S_E, S_F, S_A}; n = 6; end
      "1": begin lst = '{S_B, S_C, S_A, S_A, S_A, S_A, S_A}; n = 2; end
      "2": begin lst = '{S_A, S_B, S_G, S_E, S_D, S_A, S_A}; n = 5; end
      "3": begin lst = '{S_A, S_B, S_G, S_C, S_D, S_A, S_A}; n = 5; end
      "4": begin lst = '{S_F, S_G, S_B, S_C, S_A, S_A, S_A}; n = 4; end
      "5", "S": begin lst = '{S_A, S_F, S_G, S_C, S_D, S_A, S_A}; n = 5; end
      "6": begin lst = '{S_A, S_F, S_G, S_E, S_C, S_D, S_A}; n = 6; end
      "7": begin lst = '{S_A, S_B, S_C, S_A, S_A, S_A, S_A}; n = 3; end
      "8": begin lst = '{S_A, S_B, S_C, S_D, S_E, S_F, S_G}; n = 7; end
      "9": begin lst = '{S_A, S_B, S_C, S_D, S_F, S_G, S_A}; n = 6; end
      ".": begin lst[0] = S_DOT; n = 1; end
      "-": begin lst[0] = S_G; n = 1; end
      "F": begin lst = '{S_V, S_A, S_G, S_A, S_A, S_A, S_A}; n = 3; end
      "P": begin lst = '{S_V, S_A, S_B, S_G, S_A, S_A, S_A}; n = 4; end
      "M": begin lst = '{S_M1, S_M2, S_M3, S_M4, S_A, S_A, S_A}; n = 4; end
      default: n = 0;
    endcase
    return n;
  endfunction

  function automatic void stroke_nodes(stroke_id_t s, output node_t a, output node_t b);
    case (s)
      S_A:     begin a = N_TL; b = N_TR; end
      S_B:     begin a = N_TR; b = N_MR; end
      S_C:     begin a = N_MR; b = N_BR; end
      S_D:     begin a = N_BL; b = N_BR; end
      S_E:     begin a = N_BL; b = N_ML; end
      S_F:     begin a = N_TL; b = N_ML; end
      S_G:     begin a = N_ML; b = N_MR; end
      S_V:     begin a = N_TL; b = N_BL; end
      S_M1:    begin a = N_BL; b = N_TL; end
      S_M2:    begin a = N_BR; b = N_TR; end
      S_M3:    begin a = N_TL; b = N_MM; end
      S_M4:    begin a = N_MM; b = N_TR; end
      default: begin a = N_DA; b = N_DB; end
    endcase
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("(%0d,%0d)-(%0d,%0d) seg=%0b last=%0b width=%0d", r.start_x, r.start_y,
                     r.end_x, r.end_y, r.segment_valid, r.last_of_glyph, r.text_width);
  endfunction

  task automatic draw_char(in_item_t it);
    logic [COORD_W-1:0] nx [9];
    logic [COORD_W-1:0] ny [9];
    stroke_id_t         lst [7];
    node_t              a;
    node_t              b;
    int                 n;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] next_pen;
    logic [COORD_W-1:0] width;
    out_item_t          seg;
    if (it.first_char) begin
      pen_x = it.origin_x;
      string_x = it.origin_x;
      string_y = it.origin_y;
    end
    w = scaled(height, 6, 10);
    nx = '{default: '0};
    ny = '{default: '0};
    nx[N_TR] = w;
    nx[N_MR] = w;
    nx[N_BR] = w;
    ny[N_ML] = scaled(height, 1, 2);
    ny[N_MR] = ny[N_ML];
    ny[N_BL] = COORD_W'(height);
    ny[N_BR] = COORD_W'(height);
    nx[N_DA] = scaled(height, 21, 100);
    ny[N_DA] = COORD_W'(height);
    nx[N_DB] = scaled(height, 33, 100);
    ny[N_DB] = COORD_W'(height);
    nx[N_MM] = scaled(height, 3, 10);
    ny[N_MM] = scaled(height, 55, 100);
    next_pen = pen_x + scaled(height, 81, 100);
    width = next_pen - string_x;
    n = glyph_strokes(it.char_code, lst);
    for (int k = 0; k < n; k++) begin
      stroke_nodes(lst[k], a, b);
      seg = '0;
      seg.start_x = pen_x + nx[a];
      seg.start_y = string_y + ny[a];
      seg.end_x = pen_x + nx[b];
      seg.end_y = string_y + ny[b];
      seg.segment_valid = 1'b1;
      seg.last_of_glyph = (k == n - 1);
      if (k == n - 1 && it.last_char) seg.text_width = width;
      queue_result(seg);
    end
    // blank glyph only reports the width when it closes the string
    if (n == 0 && it.last_char) begin
      seg = '0;
      seg.last_of_glyph = 1'b1;
      seg.text_width = width;
      queue_result(seg);
    end
    pen_x = next_pen;
  endtask

  task automatic check_segment(out_item_t got);
    out_item_t want;
    string     diffs;
    segments_checked++;
    if (expected_segs.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result transfer: %s", show(got));
      return;
    end
    want = expected_segs.pop_front();
    diffs = "";
    if (got.start_x !== want.start_x) diffs = {diffs, " start_x"};
    if (got.start_y !== want.start_y) diffs = {diffs, " start_y"};
    if (got.end_x !== want.end_x) diffs = {diffs, " end_x"};
    if (got.end_y !== want.end_y) diffs = {diffs, " end_y"};
    if (got.segment_valid !== want.segment_valid) diffs = {diffs, " segment_valid"};
    if (got.last_of_glyph !== want.last_of_glyph) diffs = {diffs, " last_of_glyph"};
    if (got.text_width !== want.text_width) diffs = {diffs, " text_width"};
    if (diffs != "") begin
      errors++;
      if (errors <= 10) begin
        $display("result %0d differs in%s at %0t", segments_checked, diffs, $realtime);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      height = HEIGHT_RESET;
      pen_x = '0;
      string_x = '0;
      string_y = '0;
      expected_segs.delete();
      errors = 0;
      outstanding = 0;
      segments_checked = 0;
    end else begin
      if (psel && penable && pready && paddr == ADDR_GLYPH_HEIGHT) begin
        if (pwrite) begin
          height = pwdata[HEIGHT_W-1:0];
        end else if (prdata !== 32'(height)) begin
          errors++;
          if (errors <= 10) $display("glyph_height readback: expected %0d, actual %0d",
                                     height, prdata);
        end
      end
      if (out_valid && !out_stall) check_segment(out_data);
      if (in_valid && !in_stall) draw_char(in_data);
      outstanding = expected_segs.size();
    end
  end

endmodule

// ===== tb/sv/stroke_font_segment_generator_tb.sv =====
`timescale 1ns / 1ps
module stroke_font_segment_generator_tb;
  import sfsg_pkg::*;

  localparam int    QUIET_LIMIT = 1000;
  localparam int    DRAIN_CYCLES = 20;
  localparam int    PHASES = 6;
  localparam int    PHASE_CHARS = 28;
  localparam string GLYPHS = "0123456789.-FPSM";

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int errors;
  int outstanding;
  int segments_checked;
  int chars_sent;
  int strings_sent;
  int heights_used;
  int quiet;
  bit calm;

  stroke_font_segment_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  stroke_font_segment_generator_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .errors           (errors),
    .outstanding      (outstanding),
    .segments_checked (segments_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return GLYPHS[$urandom_range(0, GLYPHS.len() - 1)];
    if (r < 90) return " ";
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t char_item(logic [7:0] c, bit first, bit last);
    in_item_t it;
    it.char_code = c;
    it.first_char = first;
    it.last_char = last;
    it.origin_x = COORD_W'($urandom);
    it.origin_y = COORD_W'($urandom);
    return it;
  endfunction

  task automatic send_char(in_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    if (it.first_char) strings_sent++;
  endtask

  // block idle: nothing expected, and blank characters given time to finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_access(bit write, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= ADDR_GLYPH_HEIGHT;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
      begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("no transfer for %0d cycles at %0t", QUIET_LIMIT, $realtime);
        $display("** stroke_font_segment_generator: FAILED **");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int stall_left;
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    in_item_t          it;
    logic [HEIGHT_W-1:0] heights [PHASES];
    int                phase_chars;
    int                len;
    bit                broken;
    bit                carry;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    quiet = 0;
    chars_sent = 0;
    strings_sent = 0;
    heights_used = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no first character yet: pen and origin still at zero
    send_char(char_item("8", 1'b0, 1'b0));
    it = char_item("0", 1'b1, 1'b0);
    it.origin_x = 24'h7fffff;
    it.origin_y = 24'h800000;
    send_char(it);
    for (int i = 1; i < GLYPHS.len(); i++) send_char(char_item(GLYPHS[i], 1'b0, 1'b0));
    send_char(char_item(" ", 1'b0, 1'b0));
    send_char(char_item(8'hff, 1'b0, 1'b1));
    it = char_item("M", 1'b1, 1'b1);
    it.origin_x = 24'h800000;
    it.origin_y = 24'h7fffff;
    send_char(it);
    send_char(char_item(" ", 1'b1, 1'b1));

    heights = '{16'd0, 16'hffff, 16'd1, HEIGHT_W'($urandom), 16'd2560,
                HEIGHT_W'($urandom_range(256, 8191))};
    for (int p = 0; p < PHASES; p++) begin
      settle();
      cfg_access(1'b1, 32'(heights[p]));
      cfg_access(1'b0, 32'd0);
      heights_used++;
      // sometimes keep drawing on the string left open across the height change
      carry = $urandom_range(0, 2) == 0;
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        len = $urandom_range(1, 8);
        broken = $urandom_range(0, 7) == 0;
        calm = $urandom_range(0, 4) == 0;
        for (int i = 0; i < len; i++) begin
          if (broken) begin
            it = char_item(pick_char(), 1'($urandom), 1'($urandom));
          end else begin
            it = char_item(pick_char(), i == 0 && !carry, i == len - 1);
          end
          send_char(it);
        end
        carry = 1'b0;
        phase_chars += len;
      end
      calm = 1'b0;
    end

    settle();
    $display("%0d characters in %0d strings at %0d glyph heights, %0d result transfers checked",
             chars_sent, strings_sent, heights_used, segments_checked);
    if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("** stroke_font_segment_generator: PASSED **");
    end else begin
      $display("** stroke_font_segment_generator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sfsg_pkg.sv
design/sfsg_scaler.sv
design/sfsg_ctrl.sv
design/sfsg_datapath.sv
design/stroke_font_segment_generator.sv
tb/sv/stroke_font_segment_generator_checker.sv
tb/sv/stroke_font_segment_generator_tb.sv
